FILE: sv/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg
// Shared constants, types and helper functions of the grouped random
// permutation block.
// ----------------------------------------------------------------------------
`default_nettype none

package grp_pkg;

    // Sizing
    localparam int SLOTS       = 32;
    localparam int GROUP_LIMIT = 9;
    localparam int MAX_SET     = 64;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SET_W  = $clog2(MAX_SET + 1);
    localparam int GRP_W  = $clog2(GROUP_LIMIT + 1);

    // Field widths
    localparam int FRAC_W = 24;
    localparam int MINV_W = 8;
    localparam int NUMV_W = 6;
    localparam int TOT_W  = 7;
    localparam int VAL_W  = 9;
    localparam int POS_W  = 6;

    // Register port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_MIN_VALUE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_VALUES  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOTAL_COUNT = 2'd2;

    localparam logic [MINV_W-1:0] MINV_RESET = 8'd0;
    localparam logic [NUMV_W-1:0] NUMV_RESET = 6'd16;
    localparam logic [TOT_W-1:0]  TOT_RESET  = 7'd21;

    // Scan unit control and status
    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] k;      // free slots to skip
        logic [SLOT_W-1:0] last;   // highest slot to look at
    } t_scan_ctl;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_scan_sts;

    // Pool size, clamped to 1..SLOTS
    function automatic logic [CNT_W-1:0] pool_size(input logic [NUMV_W-1:0] nv);
        int n;
        n = int'(nv);
        if (n < 1) n = 1;
        if (n > SLOTS) n = SLOTS;
        return CNT_W'(n);
    endfunction

    // Set size, clamped to 1..MAX_SET
    function automatic logic [SET_W-1:0] set_size(input logic [TOT_W-1:0] tc);
        int t;
        t = int'(tc);
        if (t < 1) t = 1;
        if (t > MAX_SET) t = MAX_SET;
        return SET_W'(t);
    endfunction

    // Outputs of one round: min of pool size, group limit and what the set needs
    function automatic logic [GRP_W-1:0] group_len(input logic [CNT_W-1:0] n,
                                                   input logic [SET_W-1:0] left);
        int g;
        g = int'(n);
        if (g > GROUP_LIMIT) g = GROUP_LIMIT;
        if (int'(left) < g) g = int'(left);
        return GRP_W'(g);
    endfunction

    localparam logic [GRP_W-1:0] GRP_RESET = group_len(pool_size(NUMV_RESET), set_size(TOT_RESET));

endpackage

`default_nettype wire

FILE: sv/grouped_random_permutation.sv
// ----------------------------------------------------------------------------
// grouped_random_permutation
// Draws values without replacement from a configurable pool and emits them
// in groups that make up sets of a configurable size.
// ----------------------------------------------------------------------------
// Each request carries one 0.24 random fraction and performs one draw: the
// fraction times the count of free slots gives k, and a serial scanner walks
// the taken bitmap one slot per cycle to the k-th free slot. The request
// input stays stalled while a draw passes through the scan and done
// states, so a new request is taken only once the previous draw has
// finished. A result, when the draw falls inside the current group, sits in
// an output register, and the next request is taken while it waits; a draw
// that needs the output register while the previous result is still stalled
// there holds the block, and the request input stays stalled until that
// result is taken.
// Configuration registers lie at byte addresses 0 (min_value), 4 (num_values)
// and 8 (total_count); a write can also affect a draw in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_random_permutation (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [grp_pkg::FRAC_W-1:0]    i_random_fraction,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [grp_pkg::VAL_W-1:0]          o_value,
    output logic [grp_pkg::POS_W-1:0]          o_position,
    output logic                               o_last_of_set,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [grp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [grp_pkg::DATA_W-1:0]    pwdata,
    output logic [grp_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int PROD_W = grp_pkg::FRAC_W + grp_pkg::CNT_W;

    // configuration
    logic [grp_pkg::MINV_W-1:0]    r_minv;
    logic [grp_pkg::NUMV_W-1:0]    r_numv;
    logic [grp_pkg::TOT_W-1:0]     r_tot;

    // draw state
    logic [1:0]                    r_state;
    logic [grp_pkg::SLOTS-1:0]     r_taken;
    logic [grp_pkg::CNT_W-1:0]     r_draw;
    logic [grp_pkg::GRP_W-1:0]     r_grp;
    logic [grp_pkg::SET_W-1:0]     r_prod;
    logic [grp_pkg::SLOT_W-1:0]    r_slot;
    logic                          r_out_valid;

    logic [grp_pkg::CNT_W-1:0]     pool_n;
    logic [grp_pkg::SET_W-1:0]     set_total;
    logic                          wrap_now;
    logic [grp_pkg::CNT_W-1:0]     draw_eff;
    logic [grp_pkg::SET_W-1:0]     prod_eff;
    logic [grp_pkg::SET_W-1:0]     set_left;
    logic [grp_pkg::CNT_W-1:0]     remaining;
    logic [PROD_W-1:0]             product;
    logic                          in_acc;
    logic                          emit;
    logic                          out_free;
    logic                          fin;
    logic                          last;
    logic [grp_pkg::CNT_W-1:0]     draw_inc;
    logic                          wrap_end;
    logic                          cfg_wr;
    logic [grp_pkg::REG_IDX_W-1:0] reg_idx;

    grp_pkg::t_scan_ctl            scan_ctl;
    grp_pkg::t_scan_sts            scan_sts;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[grp_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minv <= grp_pkg::MINV_RESET;
            r_numv <= grp_pkg::NUMV_RESET;
            r_tot  <= grp_pkg::TOT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                grp_pkg::REG_MIN_VALUE:   r_minv <= pwdata[grp_pkg::MINV_W-1:0];
                grp_pkg::REG_NUM_VALUES:  r_numv <= pwdata[grp_pkg::NUMV_W-1:0];
                grp_pkg::REG_TOTAL_COUNT: r_tot  <= pwdata[grp_pkg::TOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            grp_pkg::REG_MIN_VALUE:   prdata = grp_pkg::DATA_W'(r_minv);
            grp_pkg::REG_NUM_VALUES:  prdata = grp_pkg::DATA_W'(r_numv);
            grp_pkg::REG_TOTAL_COUNT: prdata = grp_pkg::DATA_W'(r_tot);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request acceptance: round start and k
    // ------------------------------------------------------------------
    assign o_stall   = (r_state != ST_IDLE);
    assign in_acc    = i_valid && (r_state == ST_IDLE);

    assign pool_n    = grp_pkg::pool_size(r_numv);
    assign set_total = grp_pkg::set_size(r_tot);

    // pool shrunk under the current round: start a new one
    assign wrap_now  = (int'(r_draw) >= int'(pool_n));
    assign draw_eff  = wrap_now ? '0 : r_draw;
    assign prod_eff  = (r_prod >= set_total) ? '0 : r_prod;
    assign set_left  = set_total - prod_eff;
    assign remaining = pool_n - draw_eff;
    assign product   = PROD_W'(i_random_fraction) * PROD_W'(remaining);

    assign scan_ctl.start = in_acc;
    assign scan_ctl.k     = product[grp_pkg::FRAC_W +: grp_pkg::SLOT_W];
    assign scan_ctl.last  = grp_pkg::SLOT_W'(pool_n - grp_pkg::CNT_W'(1));

    grp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_taken (r_taken),
        .o_sts   (scan_sts)
    );

    // ------------------------------------------------------------------
    // Draw completion
    // ------------------------------------------------------------------
    assign emit     = (int'(r_draw) < int'(r_grp));
    assign out_free = !r_out_valid || !i_stall;
    assign fin      = (r_state == ST_DONE) && (!emit || out_free);
    assign last     = (int'(r_prod) + 1 >= int'(set_total));
    assign draw_inc = r_draw + grp_pkg::CNT_W'(1);
    assign wrap_end = (int'(draw_inc) >= int'(pool_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_taken     <= '0;
            r_draw      <= '0;
            r_grp       <= grp_pkg::GRP_RESET;
            r_prod      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin && emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_draw <= draw_eff;
                        if (wrap_now) begin
                            r_taken <= '0;
                        end
                        if (draw_eff == '0) begin
                            r_prod <= prod_eff;
                            r_grp  <= grp_pkg::group_len(pool_n, set_left);
                        end
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_sts.done) begin
                        if (scan_sts.found) begin
                            r_taken[scan_sts.slot] <= 1'b1;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold while a result is needed and the output is blocked
                    if (fin) begin
                        if (emit) begin
                            r_prod <= last ? '0 : r_prod + grp_pkg::SET_W'(1);
                        end
                        if (wrap_end) begin
                            r_draw  <= '0;
                            r_taken <= '0;
                        end else begin
                            r_draw <= draw_inc;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // slot of this draw; a pool with no free slot left in range gives slot 0
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && scan_sts.done) begin
            r_slot <= scan_sts.found ? scan_sts.slot : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin && emit) begin
            o_value       <= grp_pkg::VAL_W'(r_slot) + grp_pkg::VAL_W'(r_minv);
            o_position    <= grp_pkg::POS_W'(r_prod);
            o_last_of_set <= last;
        end
    end

    assign o_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_sts.done |-> (r_state == ST_SCAN))
        else $error("scan finished outside of the scan state");

    a_scan_hits_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_sts.done && scan_sts.found) |-> !r_taken[scan_sts.slot])
        else $error("scan picked a slot that is already taken");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result appeared without a finished draw");

endmodule

`default_nettype wire

FILE: sv/grp_scan.sv
// ----------------------------------------------------------------------------
// grp_scan
// Serial free-slot finder: walks the taken bitmap one slot per cycle and
// stops at the k-th free slot or at the last slot of the pool.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_scan (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire grp_pkg::t_scan_ctl         i_ctl,
    input  wire logic [grp_pkg::SLOTS-1:0]  i_taken,
    output grp_pkg::t_scan_sts              o_sts
);

    logic                         r_busy;
    logic [grp_pkg::SLOT_W-1:0]   r_j;
    logic [grp_pkg::SLOT_W-1:0]   r_k;
    logic [grp_pkg::SLOT_W-1:0]   r_last;
    logic                         free;
    logic                         hit;
    logic                         at_end;

    assign free   = !i_taken[r_j];
    assign hit    = r_busy && free && (r_k == '0);
    assign at_end = (r_j == r_last);

    assign o_sts.done  = r_busy && (hit || at_end);
    assign o_sts.found = hit;
    assign o_sts.slot  = r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
        end else if (o_sts.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_j    <= '0;
            r_k    <= i_ctl.k;
            r_last <= i_ctl.last;
        end else if (r_busy && !o_sts.done) begin
            r_j <= r_j + grp_pkg::SLOT_W'(1);
            // skip over this free slot
            if (free) begin
                r_k <= r_k - grp_pkg::SLOT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
